// ===== rtl/lnbdr_pkg.sv =====
package lnbdr_pkg;

    // neuron size and epoch length
    localparam int NUM_INPUTS = 7;
    localparam int SAMPLES    = 2048;

    // field and state widths
    localparam int DIG_W   = 4;
    localparam int W_W     = 32;
    localparam int D_W     = 48;
    localparam int E_W     = 64;
    localparam int LR_W    = 16;
    localparam int OUT_E_W = 48;
    localparam int FRAC    = 16;
    localparam int FUNC_W  = 2;

    // element index and sweep counter
    localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int CNT_W = $clog2(NUM_INPUTS + 1);

    // datapath widths
    localparam int ACC_W   = W_W + DIG_W + CNT_W + 1;
    localparam int ERR_W   = ACC_W + 1;
    localparam int RE_W    = ERR_W + LR_W + 1;
    localparam int PROD_W  = RE_W + DIG_W + 1;
    localparam int DSUM_W  = ((PROD_W - FRAC > D_W) ? PROD_W - FRAC : D_W) + 1;
    localparam int WSUM_W  = D_W + 1;
    localparam int SHIFT_K = $clog2(SAMPLES + 1) - 1;

    // stream payload widths
    localparam int IN_DATA_W  = ((DIG_W * NUM_INPUTS + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + OUT_E_W + 7) / 8) * 8;

    // register port
    localparam int CFG_ADDR_W = $clog2(4 * (NUM_INPUTS + 1));
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [LR_W-1:0] LR_RESET = 16'd655;

    // fixed point one
    localparam int ONE_Q16 = 65536;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_TRAIN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREDICT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // result kinds
    localparam logic KIND_PRED  = 1'b0;
    localparam logic KIND_EPOCH = 1'b1;

endpackage

// ===== rtl/lnbdr_ram.sv =====
module lnbdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/linear_neuron_batch_delta_rule_top.sv =====
// channel   | direction | transfer when            | payload
// s_axis    | in        | tvalid & tready          | tuser func, tdata digits+target, tlast
// m_axis    | out       | tvalid & tready          | tuser kind, tdata prediction+error
// apb       | in        | psel & penable & pwrite  | init weights, learning rate
//
// one item at a time; the weight and delta memories each have one read port,
// so every pass over the inputs reads them one element at a time.
// train: sum, error, rate times error, update pass; an output step only on the last item of an epoch.
// predict: sum, error, output; restart: writes the init weights into the weight memory.
// reset is synchronous; memories need no clearing, per-entry valid bits read as zero.
// a waiting result sits in the output register while the next item is taken.
module linear_neuron_batch_delta_rule_top
    import lnbdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // digit_0 .. digit_6, target
    input  logic [FUNC_W-1:0]     i_s_axis_tuser,   // func
    input  logic                  i_s_axis_tlast,   // last
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // prediction, epoch_error
    output logic                  o_m_axis_tuser,   // kind
    // register port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_RE   = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_RST  = 3'd6;

    // control state
    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_pv, n_pv;
    logic [IDX_W-1:0]        r_pidx, n_pidx;
    logic [NUM_INPUTS-1:0]   r_wv, n_wv;
    logic [NUM_INPUTS-1:0]   r_dv, n_dv;
    logic                    r_mv, n_mv;

    // datapath state
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic signed [RE_W-1:0]  r_re, n_re;
    logic [E_W-1:0]          r_sq, n_sq;
    logic                    r_big, n_big;
    logic [E_W-1:0]          r_energy, n_energy;
    logic                    r_res_kind, n_res_kind;
    logic                    r_res_pred, n_res_pred;
    logic [OUT_E_W-1:0]      r_res_err, n_res_err;

    // latched item
    logic [FUNC_W-1:0]       r_func;
    logic [DIG_W-1:0]        r_dig [NUM_INPUTS];
    logic                    r_tgt;
    logic                    r_last;

    // output register
    logic                    r_m_kind;
    logic                    r_m_pred;
    logic [OUT_E_W-1:0]      r_m_err;

    // configuration registers
    logic [W_W-1:0]          r_cfg_w [NUM_INPUTS];
    logic [LR_W-1:0]         r_lr;

    // memory ports
    logic                    w_we, d_we;
    logic [IDX_W-1:0]        w_waddr, d_waddr, rd_addr;
    logic [W_W-1:0]          w_wdata, w_rdata;
    logic [D_W-1:0]          d_wdata, d_rdata;

    // datapath wires
    logic                    s_acc, out_free, out_load, issue;
    logic [DIG_W-1:0]        dig_p;
    logic signed [W_W-1:0]   w_eff;
    logic signed [D_W-1:0]   d_eff;
    logic signed [W_W+DIG_W:0] mac_prod;
    logic signed [ERR_W-1:0] tgt_q, err_val;
    logic [ERR_W-1:0]        mag;
    logic signed [PROD_W-1:0] upd_prod, upd_shift;
    logic signed [DSUM_W-1:0] dsum;
    logic signed [D_W-1:0]   d_new;
    logic signed [WSUM_W-1:0] wsum;
    logic signed [W_W-1:0]   w_new;
    logic [E_W-1:0]          e_term;
    logic [E_W:0]            e_sum;
    logic [E_W-2:0]          e_half;
    logic [OUT_E_W-1:0]      e_out;
    logic                    cfg_wr;
    logic [CFG_IDX_W-1:0]    cfg_idx;

    // handshakes
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_mv || i_m_axis_tready;
    assign issue           = (r_cnt < CNT_W'(NUM_INPUTS));

    // memories, both read at the same element
    assign rd_addr = issue ? r_cnt[IDX_W-1:0] : '0;

    lnbdr_ram #(.WIDTH(W_W), .DEPTH(NUM_INPUTS)) u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (rd_addr),
        .o_rdata (w_rdata)
    );

    lnbdr_ram #(.WIDTH(D_W), .DEPTH(NUM_INPUTS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (rd_addr),
        .o_rdata (d_rdata)
    );

    // entries never written read as zero
    assign dig_p = r_dig[r_pidx];
    assign w_eff = r_wv[r_pidx] ? w_rdata : '0;
    assign d_eff = r_dv[r_pidx] ? d_rdata : '0;

    // dot product term
    assign mac_prod = (W_W+DIG_W+1)'(w_eff) * (W_W+DIG_W+1)'($signed({1'b0, dig_p}));

    // error against target
    assign tgt_q   = r_tgt ? ERR_W'(ONE_Q16) : ERR_W'(-ONE_Q16);
    assign err_val = tgt_q - ERR_W'(r_acc);
    assign mag     = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);

    // delta accumulate with 48-bit saturation
    assign upd_prod  = PROD_W'(r_re) * PROD_W'($signed({1'b0, dig_p}));
    assign upd_shift = upd_prod >>> FRAC;
    assign dsum      = DSUM_W'(upd_shift) + DSUM_W'(d_eff);

    always_comb begin
        if ((&dsum[DSUM_W-1:D_W-1]) || !(|dsum[DSUM_W-1:D_W-1])) begin
            d_new = dsum[D_W-1:0];
        end else if (dsum[DSUM_W-1]) begin
            d_new = {1'b1, {(D_W-1){1'b0}}};
        end else begin
            d_new = {1'b0, {(D_W-1){1'b1}}};
        end
    end

    // weight update with 32-bit saturation
    assign wsum = WSUM_W'(w_eff) + WSUM_W'(d_new >>> SHIFT_K);

    always_comb begin
        if ((&wsum[WSUM_W-1:W_W-1]) || !(|wsum[WSUM_W-1:W_W-1])) begin
            w_new = wsum[W_W-1:0];
        end else if (wsum[WSUM_W-1]) begin
            w_new = {1'b1, {(W_W-1){1'b0}}};
        end else begin
            w_new = {1'b0, {(W_W-1){1'b1}}};
        end
    end

    // energy accumulate and epoch result
    assign e_term = r_big ? '1 : E_W'(r_sq[E_W-1:FRAC]);
    assign e_sum  = {1'b0, r_energy} + {1'b0, e_term};
    assign e_half = r_energy[E_W-1:1];
    assign e_out  = (|e_half[E_W-2:OUT_E_W]) ? '1 : e_half[OUT_E_W-1:0];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_wv       = r_wv;
        n_dv       = r_dv;
        n_acc      = r_acc;
        n_err      = r_err;
        n_re       = r_re;
        n_sq       = r_sq;
        n_big      = r_big;
        n_energy   = r_energy;
        n_res_kind = r_res_kind;
        n_res_pred = r_res_pred;
        n_res_err  = r_res_err;
        n_mv       = r_mv && !i_m_axis_tready;
        out_load   = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_pidx;
        w_wdata    = w_new;
        d_we       = 1'b0;
        d_waddr    = r_pidx;
        d_wdata    = d_new;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (i_s_axis_tuser)
                        FUNC_TRAIN, FUNC_PREDICT: begin
                            n_state = S_SUM;
                            n_cnt   = '0;
                            n_acc   = ACC_W'(-ONE_Q16);
                        end
                        FUNC_RESTART: begin
                            n_state  = S_RST;
                            n_cnt    = '0;
                            n_dv     = '0;
                            n_energy = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SUM: begin
                if (issue) begin
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_cnt[IDX_W-1:0];
                end else begin
                    n_state = S_ERR;
                end
                if (r_pv) begin
                    n_acc = r_acc + ACC_W'(mac_prod);
                end
            end
            S_ERR: begin
                n_err = err_val;
                if (r_func == FUNC_PREDICT) begin
                    n_res_kind = KIND_PRED;
                    n_res_pred = !r_acc[ACC_W-1] && (|r_acc);
                    n_res_err  = '0;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_RE;
                end
            end
            S_RE: begin
                n_re    = RE_W'($signed({1'b0, r_lr})) * RE_W'(r_err);
                n_sq    = E_W'(mag[31:0]) * E_W'(mag[31:0]);
                n_big   = |mag[ERR_W-1:32];
                n_cnt   = '0;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (r_cnt == '0) begin
                    n_energy = e_sum[E_W] ? '1 : e_sum[E_W-1:0];
                end
                if (issue) begin
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_cnt[IDX_W-1:0];
                end
                if (r_pv) begin
                    if (r_last) begin
                        w_we         = 1'b1;
                        n_wv[r_pidx] = 1'b1;
                        n_dv[r_pidx] = 1'b0;
                    end else begin
                        d_we         = 1'b1;
                        n_dv[r_pidx] = 1'b1;
                    end
                end
                if (!issue) begin
                    if (r_last) begin
                        n_res_kind = KIND_EPOCH;
                        n_res_pred = 1'b0;
                        n_res_err  = e_out;
                        n_energy   = '0;
                        n_state    = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_mv     = 1'b1;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RST: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[IDX_W-1:0];
                w_wdata = r_cfg_w[r_cnt[IDX_W-1:0]];
                n_wv[r_cnt[IDX_W-1:0]] = 1'b1;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_INPUTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_wv     <= '0;
            r_dv     <= '0;
            r_mv     <= 1'b0;
            r_energy <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            r_wv     <= n_wv;
            r_dv     <= n_dv;
            r_mv     <= n_mv;
            r_energy <= n_energy;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_acc      <= n_acc;
        r_err      <= n_err;
        r_re       <= n_re;
        r_sq       <= n_sq;
        r_big      <= n_big;
        r_res_kind <= n_res_kind;
        r_res_pred <= n_res_pred;
        r_res_err  <= n_res_err;
        if (s_acc) begin
            r_func <= i_s_axis_tuser;
            r_tgt  <= i_s_axis_tdata[DIG_W*NUM_INPUTS];
            r_last <= i_s_axis_tlast;
            for (int k = 0; k < NUM_INPUTS; k++) begin
                r_dig[k] <= i_s_axis_tdata[DIG_W*k +: DIG_W];
            end
        end
        if (out_load) begin
            r_m_kind <= r_res_kind;
            r_m_pred <= r_res_pred;
            r_m_err  <= r_res_err;
        end
    end

    // result stream
    assign o_m_axis_tvalid = r_mv;
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_m_err, r_m_pred});

    // register port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_INPUTS; k++) begin
                r_cfg_w[k] <= '0;
            end
            r_lr <= LR_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx < CFG_IDX_W'(NUM_INPUTS)) begin
                r_cfg_w[cfg_idx[IDX_W-1:0]] <= i_pwdata[W_W-1:0];
            end else if (cfg_idx == CFG_IDX_W'(NUM_INPUTS)) begin
                r_lr <= i_pwdata[LR_W-1:0];
            end
        end
    end

    // register readback
    always_comb begin
        if (cfg_idx < CFG_IDX_W'(NUM_INPUTS)) begin
            o_prdata = r_cfg_w[cfg_idx[IDX_W-1:0]];
        end else if (cfg_idx == CFG_IDX_W'(NUM_INPUTS)) begin
            o_prdata = 32'(r_lr);
        end else begin
            o_prdata = '0;
        end
    end

endmodule

// ===== rtl/lnbdr_checker.sv =====
module lnbdr_checker
    import lnbdr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [FUNC_W-1:0]     i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a real operation keeps the input side busy in the next cycle
    a_busy_after_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready &&
         (i_s_axis_tuser == FUNC_TRAIN || i_s_axis_tuser == FUNC_PREDICT ||
          i_s_axis_tuser == FUNC_RESTART)) |=> !o_s_axis_tready)
        else $error("input taken while an item is in progress");

    // prediction results carry no error, epoch results no prediction
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tuser == KIND_PRED && o_m_axis_tdata[OUT_E_W:1] == '0) ||
             (o_m_axis_tuser == KIND_EPOCH && !o_m_axis_tdata[0])))
        else $error("result fields inconsistent with kind");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind linear_neuron_batch_delta_rule_top lnbdr_checker u_lnbdr_checker (.*);
